// ----- hw/rtl/fsop_pkg.sv -----
`timescale 1ns / 1ps

package fsop_pkg;

  // fixed field widths
  localparam int ADDR_W      = 48;
  localparam int SIZE_W      = 13;
  localparam int COUNT_W     = 11;
  localparam int SS_W        = 14;   // rounded slot size, up to 8192
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - 2 - COUNT_W;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  // register reset values
  localparam logic [ADDR_W-1:0]  RST_BASE  = '0;
  localparam logic [SIZE_W-1:0]  RST_SIZE  = 13'd8;
  localparam logic [COUNT_W-1:0] RST_COUNT = 11'd1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MISALIGN = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic sweep_step;
    logic take_in;
    logic alloc_mul;
    logic alloc_empty;
    logic alloc_commit;
    logic free_sub;
    logic range_fail;
    logic div_start;
    logic free_commit;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic head_end;
    logic range_bad;
    logic div_busy;
  } sts_t;

endpackage

// ----- hw/rtl/fsop_div.sv -----
`timescale 1ns / 1ps

module fsop_div #(
  parameter int IDX_W = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [IDX_W+fsop_pkg::SS_W-1:0]     dividend,
  input  logic [fsop_pkg::SS_W-1:0]           divisor,
  output logic                                busy,
  output logic [IDX_W-1:0]                    quotient,
  output logic                                rem_zero
);
  import fsop_pkg::*;

  localparam int OFF_W = IDX_W + SS_W;
  localparam int DS_W  = OFF_W - 1;
  localparam int CNT_W = $clog2(IDX_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [OFF_W-1:0] rem_r;
  logic [DS_W-1:0]  dsh_r;
  logic [IDX_W-1:0] q_r;
  logic             fits;

  // restoring division, one quotient bit per cycle, msb first
  assign fits = rem_r >= OFF_W'(dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(IDX_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= {divisor, {(IDX_W-1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - OFF_W'(dsh_r);
      end
      q_r   <= {q_r[IDX_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;
  assign rem_zero = (rem_r == '0);

endmodule

// ----- hw/rtl/fsop_dp.sv -----
`timescale 1ns / 1ps

module fsop_dp #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_hit,
  input  logic [fsop_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsop_pkg::ADDR_W-1:0]       cfg_data,
  input  logic [fsop_pkg::ADDR_W-1:0]       in_free_address,
  input  fsop_pkg::cmd_t                    cmd,
  output fsop_pkg::sts_t                    sts,
  output logic [fsop_pkg::ADDR_W-1:0]       out_object_address,
  output fsop_pkg::status_t                 out_status,
  output logic [fsop_pkg::COUNT_W-1:0]      out_objects_in_use
);
  import fsop_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS + 1);
  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int OFF_W = IDX_W + SS_W;
  localparam logic [IDX_W-1:0] END_MARK = IDX_W'(MAX_SLOTS);
  localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_SLOTS - 1);

  // configuration and control state
  logic [ADDR_W-1:0]  base_r;
  logic [SIZE_W-1:0]  size_r;
  logic [COUNT_W-1:0] count_r;
  logic [IDX_W-1:0]   head_r;
  logic [IDX_W-1:0]   used_r;
  logic [AW-1:0]      sw_idx_r;

  // payload registers
  logic [ADDR_W-1:0]  addr_in_r;
  logic [ADDR_W-1:0]  off_r;
  logic               below_r;
  logic [OFF_W-1:0]   prod_r;
  logic [OFF_W-1:0]   space_r;
  logic [IDX_W-1:0]   rdata_r;
  logic [ADDR_W-1:0]  res_addr_r;
  status_t            res_status_r;
  logic [IDX_W-1:0]   res_used_r;
  logic [ADDR_W-1:0]  out_addr_r;
  status_t            out_status_r;
  logic [IDX_W-1:0]   out_used_r;

  // free list links
  logic [IDX_W-1:0]   mem [MAX_SLOTS];

  logic [SIZE_W-1:0]  size_eff;
  logic [SS_W-1:0]    ss;
  logic [IDX_W-1:0]   n_slots;
  logic [IDX_W-1:0]   sw_next;
  logic [IDX_W-1:0]   sw_wdata;
  logic [IDX_W-1:0]   used_inc;
  logic [IDX_W-1:0]   used_dec;
  logic [IDX_W-1:0]   div_q;
  logic               div_busy;
  logic               div_rem_zero;
  logic               free_ok;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [IDX_W-1:0]   mem_wdata;

  // slot size: zero counts as one, round up to eight bytes
  assign size_eff = (size_r == '0) ? SIZE_W'(1) : size_r;
  assign ss = {(SS_W-3)'(size_eff[SIZE_W-1:3]) + (SS_W-3)'(|size_eff[2:0]), 3'b000};

  always_comb begin
    if (count_r == '0) begin
      n_slots = IDX_W'(1);
    end else if (32'(count_r) > 32'(MAX_SLOTS)) begin
      n_slots = END_MARK;
    end else begin
      n_slots = IDX_W'(count_r);
    end
  end

  assign sw_next  = IDX_W'(sw_idx_r) + IDX_W'(1);
  assign sw_wdata = (sw_next < n_slots) ? sw_next : END_MARK;
  assign used_inc = (used_r < END_MARK) ? used_r + IDX_W'(1) : used_r;
  assign used_dec = (used_r != '0) ? used_r - IDX_W'(1) : used_r;
  assign free_ok  = cmd.free_commit && div_rem_zero;

  fsop_div #(
    .IDX_W (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (off_r[OFF_W-1:0]),
    .divisor  (ss),
    .busy     (div_busy),
    .quotient (div_q),
    .rem_zero (div_rem_zero)
  );

  // link memory: one write port (sweep or push), one read port (pop)
  assign mem_we    = cmd.sweep_step || free_ok;
  assign mem_waddr = cmd.sweep_step ? sw_idx_r : div_q[AW-1:0];
  assign mem_wdata = cmd.sweep_step ? sw_wdata : head_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.alloc_mul) begin
      rdata_r <= mem[head_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= RST_BASE;
      size_r   <= RST_SIZE;
      count_r  <= RST_COUNT;
      head_r   <= '0;
      used_r   <= '0;
      sw_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE:  base_r  <= cfg_data;
          REG_SIZE:  size_r  <= cfg_data[SIZE_W-1:0];
          REG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        head_r   <= '0;
        used_r   <= '0;
        sw_idx_r <= '0;
      end else begin
        if (cmd.sweep_step) begin
          sw_idx_r <= sw_idx_r + AW'(1);
        end
        if (cmd.alloc_commit) begin
          head_r <= rdata_r;
          used_r <= used_inc;
        end
        if (free_ok) begin
          head_r <= div_q;
          used_r <= used_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    space_r <= OFF_W'(n_slots) * OFF_W'(ss);
    if (cmd.take_in) begin
      addr_in_r <= in_free_address;
    end
    if (cmd.free_sub) begin
      below_r <= addr_in_r < base_r;
      off_r   <= addr_in_r - base_r;
    end
    if (cmd.alloc_mul) begin
      prod_r <= OFF_W'(head_r) * OFF_W'(ss);
    end
    if (cmd.alloc_empty) begin
      res_addr_r   <= '0;
      res_status_r <= ST_EMPTY;
      res_used_r   <= used_r;
    end
    if (cmd.alloc_commit) begin
      res_addr_r   <= base_r + ADDR_W'(prod_r);
      res_status_r <= ST_OK;
      res_used_r   <= used_inc;
    end
    if (cmd.range_fail) begin
      res_addr_r   <= '0;
      res_status_r <= ST_RANGE;
      res_used_r   <= used_r;
    end
    if (cmd.free_commit) begin
      res_addr_r   <= '0;
      res_status_r <= div_rem_zero ? ST_OK : ST_MISALIGN;
      res_used_r   <= div_rem_zero ? used_dec : used_r;
    end
    if (cmd.load_out) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_used_r   <= res_used_r;
    end
  end

  assign sts.sweep_last = (sw_idx_r == LAST_IDX);
  assign sts.head_end   = (head_r == END_MARK);
  assign sts.range_bad  = below_r || (off_r >= ADDR_W'(space_r));
  assign sts.div_busy   = div_busy;

  assign out_object_address = out_addr_r;
  assign out_status         = out_status_r;
  assign out_objects_in_use = COUNT_W'(out_used_r);

  a_head_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= END_MARK)
    else $error("free head beyond end mark");

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= END_MARK)
    else $error("in-use count beyond pool size");

endmodule

// ----- hw/rtl/fsop_ctrl.sv -----
`timescale 1ns / 1ps

module fsop_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_hit,
  input  logic              in_tvalid,
  input  fsop_pkg::opcode_t in_op,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  output fsop_pkg::cmd_t    cmd,
  input  fsop_pkg::sts_t    sts
);
  import fsop_pkg::*;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_FREE_SUB,
    S_FREE_CHK,
    S_FREE_DIV,
    S_FREE_UPD,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take_in = 1'b1;
          state_nxt   = (in_op == OP_FREE) ? S_FREE_SUB : S_ALLOC_MUL;
        end
      end
      S_ALLOC_MUL: begin
        if (sts.head_end) begin
          cmd.alloc_empty = 1'b1;
          state_nxt       = S_RESULT;
        end else begin
          cmd.alloc_mul = 1'b1;
          state_nxt     = S_ALLOC_ADD;
        end
      end
      S_ALLOC_ADD: begin
        cmd.alloc_commit = 1'b1;
        state_nxt        = S_RESULT;
      end
      S_FREE_SUB: begin
        cmd.free_sub = 1'b1;
        state_nxt    = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (sts.range_bad) begin
          cmd.range_fail = 1'b1;
          state_nxt      = S_RESULT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_FREE_DIV;
        end
      end
      S_FREE_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_FREE_UPD;
        end
      end
      S_FREE_UPD: begin
        cmd.free_commit = 1'b1;
        state_nxt       = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_SWEEP;
      end
    endcase
    // any register write rebuilds the free list
    if (cfg_hit) begin
      state_nxt = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != S_IDLE)
    else $error("request accepted but controller stayed idle");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> !in_tready)
    else $error("request taken during free list rebuild");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("pending response overwritten");

endmodule

// ----- hw/rtl/fixed_size_object_pool.sv -----
`timescale 1ns / 1ps

// fixed-size object pool: free-list allocator for equal-size slots
// in channel: in_tuser carries the opcode (allocate or free), in_tdata the
//   byte address to free; one request at a time, taken only when idle
// out channel: one response per request with the object address, a status
//   code and the in-use count after the request
// cfg channel: always ready; writing base, size or count rebuilds the free
//   list and clears the in-use count (write only while no request is open)
// sequence: an allocate reads the link and multiplies head by slot size,
//   then adds the base and moves the head (an empty pool skips both); a
//   free subtracts the base and checks the range, and one inside the pool
//   runs the bit-serial divider that turns the byte offset into a slot index
// throughput: a new request is taken only once the previous response has
//   been loaded into the output register
// reset: the link table is rewritten as the chain 0,1,..,count-1,end, one
//   entry per cycle over all MAX_SLOTS entries (1024 at the default); in_tready stays
//   low during that sweep, and the same sweep follows every register write
// stall: a response waits in the output register while out_tready is low;
//   the next request is still accepted and worked on, and its response is
//   held back until the output register frees up
module fixed_size_object_pool #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fsop_pkg::ADDR_W-1:0]          in_tdata,   // free_address[47:0]
  input  logic [0:0]                           in_tuser,   // opcode[0]

  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // object_address[47:0], status[49:48], objects_in_use[60:50], zero[63:61]
  output logic [fsop_pkg::OUT_TDATA_W-1:0]     out_tdata,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fsop_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsop_pkg::ADDR_W-1:0]          cfg_data
);
  import fsop_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic               cfg_we;
  logic               cfg_hit;
  logic [ADDR_W-1:0]  object_address;
  status_t            status;
  logic [COUNT_W-1:0] objects_in_use;

  // register writes are never back-pressured
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  // writes past the register map are dropped and do not rebuild
  assign cfg_hit   = cfg_we && (cfg_index == REG_BASE || cfg_index == REG_SIZE ||
                                cfg_index == REG_COUNT);

  fsop_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_hit    (cfg_hit),
    .in_tvalid  (in_tvalid),
    .in_op      (opcode_t'(in_tuser[0])),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  fsop_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_hit            (cfg_hit),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_free_address    (in_tdata),
    .cmd                (cmd),
    .sts                (sts),
    .out_object_address (object_address),
    .out_status         (status),
    .out_objects_in_use (objects_in_use)
  );

  // response packing, lowest field first
  assign out_tdata = {{OUT_PAD_W{1'b0}}, objects_in_use, status, object_address};

endmodule

// ----- sim/fixed_size_object_pool_tb.sv -----
`timescale 1ns / 1ps

module fixed_size_object_pool_tb;
  import fsop_pkg::*;

  localparam int POOL_SLOTS = 1024;
  // index past the register map, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [COUNT_W-1:0] END_SLOT = 11'd1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SPREE_PHASES = 8;
  localparam int SPREE_ITEMS = 55;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [ADDR_W-1:0]  object_address;
    status_t            status;
    logic [COUNT_W-1:0] objects_in_use;
  } pool_reply_t;

  // mirror of the free list plus the replies still owed by the pool
  class pool_tracker;
    logic [COUNT_W-1:0] next_slot [POOL_SLOTS];
    logic [COUNT_W-1:0] head;
    logic [COUNT_W-1:0] in_use;
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;
    pool_reply_t        owed [$];
    int                 errors;

    // object size rounded up to eight, zero counts as one byte
    function logic [63:0] stride();
      logic [63:0] s;
      s = (size_reg == '0) ? 64'd1 : 64'(size_reg);
      return (s + 64'd7) & ~64'd7;
    endfunction

    function logic [63:0] live_slots();
      logic [63:0] c;
      c = (count_reg == '0) ? 64'd1 : 64'(count_reg);
      if (c > POOL_SLOTS) c = POOL_SLOTS;
      return c;
    endfunction

    function void relink();
      logic [63:0] n;
      n = live_slots();
      for (int i = 0; i < POOL_SLOTS; i++)
        next_slot[i] = (i + 1 < n) ? COUNT_W'(i + 1) : END_SLOT;
      head = '0;
      in_use = '0;
    endfunction

    function void power_up();
      base = RST_BASE;
      size_reg = RST_SIZE;
      count_reg = RST_COUNT;
      errors = 0;
      owed.delete();
      relink();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        REG_BASE:  base = data;
        REG_SIZE:  size_reg = data[SIZE_W-1:0];
        REG_COUNT: count_reg = data[COUNT_W-1:0];
        default:   return;
      endcase
      relink();
    endfunction

    function pool_reply_t take_request(opcode_t op, logic [ADDR_W-1:0] addr);
      pool_reply_t r;
      logic [63:0] sz;
      logic [63:0] off;
      logic [63:0] slot_addr;
      r = '0;
      r.status = ST_OK;
      sz = stride();
      if (op == OP_ALLOC) begin
        if (head >= END_SLOT) begin
          r.status = ST_EMPTY;
        end else begin
          slot_addr = 64'(base) + 64'(head) * sz;
          r.object_address = slot_addr[ADDR_W-1:0];
          head = next_slot[head];
          if (in_use < POOL_SLOTS) in_use++;
        end
      end else begin
        off = 64'(addr) - 64'(base);
        if (addr < base || off >= live_slots() * sz) begin
          r.status = ST_RANGE;
        end else if (off % sz != 0) begin
          r.status = ST_MISALIGN;
        end else begin
          next_slot[off / sz] = head;
          head = COUNT_W'(off / sz);
          if (in_use > 0) in_use--;
        end
      end
      r.objects_in_use = in_use;
      owed.push_back(r);
      return r;
    endfunction

    function void match_response(logic [OUT_TDATA_W-1:0] tdata);
      pool_reply_t want;
      logic [ADDR_W-1:0]  got_addr;
      logic [1:0]         got_status;
      logic [COUNT_W-1:0] got_in_use;
      if (owed.size() == 0) begin
        $error("response with no request outstanding, tdata %h", tdata);
        errors++;
        return;
      end
      want = owed.pop_front();
      got_addr = tdata[ADDR_W-1:0];
      got_status = tdata[ADDR_W+1:ADDR_W];
      got_in_use = tdata[ADDR_W+2+COUNT_W-1:ADDR_W+2];
      if (got_addr !== want.object_address) begin
        $error("object_address: expected %h, actual %h", want.object_address, got_addr);
        errors++;
      end
      if (got_status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got_status);
        errors++;
      end
      if (got_in_use !== want.objects_in_use) begin
        $error("objects_in_use: expected %0d, actual %0d", want.objects_in_use, got_in_use);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ADDR_W-1:0]      in_tdata;   // free_address[47:0]
  logic [0:0]             in_tuser;   // opcode[0]
  logic                   out_tvalid;
  logic                   out_tready;
  // object_address[47:0], status[49:48], objects_in_use[60:50], zero[63:61]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [ADDR_W-1:0]      cfg_data;

  pool_tracker       tracker;
  logic [ADDR_W-1:0] live_objects [$];   // addresses handed out and not yet freed
  bit                calm = 1'b0;        // no idling on either side once set
  int                cycles = 0;

  fixed_size_object_pool DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop, far above the slowest legal run including the rebuild sweeps
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // replies are checked at the rising edge they are taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_response(out_tdata);
  end

  // receiver back-pressure: short low bursts between longer ready stretches
  initial begin
    int len;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_tready = 1'b1;
        len = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_tready = 1'b0;
        len = $urandom_range(1, 9);
      end else begin
        out_tready = 1'b1;
        len = $urandom_range(1, 30);
      end
      repeat (len - 1) @(negedge clk);
    end
  end

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // byte address of slot k under the current settings, wrapping at 48 bits
  function automatic logic [ADDR_W-1:0] slot_address(logic [63:0] k);
    logic [63:0] w;
    w = 64'(tracker.base) + k * tracker.stride();
    return w[ADDR_W-1:0];
  endfunction

  // one request; valid stays high into the next request unless a gap is drawn
  task automatic send(opcode_t op, logic [ADDR_W-1:0] addr);
    pool_reply_t r;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = addr;
    do @(posedge clk); while (!in_tready);
    r = tracker.take_request(op, addr);
    if (op == OP_ALLOC && r.status == ST_OK) live_objects.push_back(r.object_address);
  endtask

  // stop sending and wait for every owed reply
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    live_objects.delete();
  endtask

  task automatic setup_pool(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                            logic [ADDR_W-1:0] count);
    write_reg(REG_BASE, base);
    write_reg(REG_SIZE, size);
    write_reg(REG_COUNT, count);
  endtask

  // mostly alloc/free pairs on live objects, the rest double frees and bad addresses
  task automatic random_request();
    int pick;
    int k;
    logic [ADDR_W-1:0] a;
    logic [63:0] sz;
    logic [63:0] nslots;
    pick = $urandom_range(0, 99);
    sz = tracker.stride();
    nslots = tracker.live_slots();
    if (pick < 45) begin
      send(OP_ALLOC, rand48());
    end else if (pick < 80 && live_objects.size() != 0) begin
      k = $urandom_range(0, live_objects.size() - 1);
      a = live_objects[k];
      live_objects.delete(k);
      send(OP_FREE, a);
    end else if (pick < 88) begin
      send(OP_FREE, slot_address($urandom_range(0, int'(nslots) - 1)));
    end else if (pick < 92) begin
      a = slot_address($urandom_range(0, int'(nslots) - 1));
      send(OP_FREE, a + $urandom_range(1, int'(sz) - 1));
    end else if (pick < 95) begin
      send(OP_FREE, tracker.base - 1'b1);
    end else if (pick < 97) begin
      send(OP_FREE, slot_address(nslots));
    end else begin
      send(OP_FREE, rand48());
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(0, 2))
      0:       return rand48();
      1:       return ADDR_W'($urandom_range(0, 4096));
      default: return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // upper data bits are sometimes junk, the pool keeps only the low field bits
  function automatic logic [ADDR_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return ADDR_W'($urandom_range(1, 64));
    if (r < 8) return ADDR_W'($urandom_range(65, 4096));
    if (r == 8) return rand48();
    return ($urandom_range(0, 1) == 0) ? '0 : ADDR_W'(8191);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return ADDR_W'($urandom_range(1, 16));
    if (r < 8) return ADDR_W'($urandom_range(17, 1024));
    return rand48();
  endfunction

  initial begin
    int n;
    int extra;
    logic [ADDR_W-1:0] b;
    tracker = new();
    tracker.power_up();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ALLOC;
    cfg_valid = 1'b0;
    cfg_index = REG_BASE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: base 0, 8-byte slots, full pool
    send(OP_ALLOC, {ADDR_W{1'b1}});   // address field ignored on allocate
    send(OP_ALLOC, '0);
    send(OP_FREE, 48'd8);
    send(OP_FREE, 48'd4);                // off a slot boundary
    send(OP_FREE, {ADDR_W{1'b1}});       // top of the address space
    send(OP_FREE, 48'd8192);             // one past the last slot
    send(OP_FREE, 48'd8184);             // last slot
    send(OP_FREE, 48'd0);                // nothing in use, count holds at zero
    send(OP_ALLOC, '0);

    // write to the unused index must leave the pool alone
    write_reg(REG_SPARE, rand48());
    send(OP_ALLOC, '0);

    // zero size and zero count fall back to one byte and one slot
    setup_pool(48'h1000, '0, '0);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);                  // pool empty
    send(OP_FREE, 48'hFFF);              // just below base
    send(OP_FREE, 48'h1008);             // past the only slot
    send(OP_FREE, 48'h1000);

    // oversize count saturates, largest size, slot addresses wrap past 48 bits
    setup_pool(48'hFFFF_FFFF_FFF0, 48'd8191, 48'd2047);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);                  // wraps around to a low address
    send(OP_FREE, 48'hFFFF_FFFF_FFF8);
    send(OP_FREE, 48'hFFFF_FFFF_FFF0);
    send(OP_FREE, 48'h0000_0000_1FF0);   // the wrapped slot lies below base

    // two-slot pool turned into a cycle by freeing slot one with nothing in use,
    // so allocation never runs dry and the in-use count climbs to its ceiling
    b = rand48();
    b[ADDR_W-1] = 1'b0;
    setup_pool(b, 48'd4096, 48'd2);
    send(OP_FREE, b + 48'd4096);
    n = 0;
    extra = 0;
    while (extra < 12 && n < 1200) begin
      if ($urandom_range(0, 39) == 0) begin
        send(OP_FREE, rand48());
      end else if ($urandom_range(0, 39) == 0) begin
        send(OP_FREE, b + ADDR_W'($urandom_range(1, 4095)));
      end else begin
        send(OP_ALLOC, rand48());
        if (tracker.in_use == POOL_SLOTS) extra++;
      end
      n++;
    end

    // random settings per phase, the first two at the register extremes
    for (int p = 0; p < SPREE_PHASES; p++) begin
      if (p == 0) setup_pool('0, 48'd1, 48'd1024);
      else if (p == 1) setup_pool({ADDR_W{1'b1}}, 48'd4096, 48'd1);
      else setup_pool(pick_base(), pick_size(), pick_count());
      if (p == SPREE_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < SPREE_ITEMS; i++) begin
        // now and then hold off until the pool has answered everything
        if (!calm && $urandom_range(0, 32) == 0) settle();
        random_request();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
